FILE: rtl/pie_pkg.sv
// shared types and constants for the particle impact estimator
`timescale 1ns / 1ps
`default_nettype none

package pie_pkg;

    localparam int unsigned T_W   = 31;           // impact time width
    localparam int unsigned REM_W = 64 + T_W;     // divider remainder width
    localparam int unsigned EPS_W = 16;

    typedef struct packed {
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic signed [31:0] offset_z;
        logic signed [31:0] velocity_x;
        logic signed [31:0] velocity_y;
        logic signed [31:0] velocity_z;
        logic signed [31:0] time_limit;
    } t_in_item;

    typedef struct packed {
        logic            hit;
        logic [T_W-1:0]  impact_time;
    } t_out_item;

    // one classified item waiting for the back end
    typedef struct packed {
        logic               away;   // moving apart
        logic [63:0]        num;    // -(offset . velocity)
        logic [63:0]        den;    // |velocity|^2
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] oz;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] vz;
        logic signed [31:0] lim;
    } t_job;

endpackage

`default_nettype wire

FILE: rtl/particle_impact_estimator.sv
// top level of the particle impact estimator
//
//  channel   direction  signals                           payload
//  in        input      i_in_valid / o_in_ready           t_in_item
//  out       output     o_out_valid / i_out_ready         t_out_item
//  cfg       input      i_cfg_we                          i_cfg_wdata (epsilon)
//
// one transaction per cycle sustained while the output is not stalled; an accepted
// input passes through the front products, one queue slot, the overflow check,
// 31 divider stages and four check stages
// synchronous active-low reset clears control state and sets epsilon to 1
// a stalled output freezes the back pipeline; the 4-entry queue and the front
// register keep taking transactions until both are full, then o_in_ready drops
`timescale 1ns / 1ps
`default_nettype none

module particle_impact_estimator import pie_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  wire              i_out_ready,
    output t_out_item        o_out_item,
    input  wire              i_cfg_we,
    input  wire [EPS_W-1:0]  i_cfg_wdata
);

    logic [EPS_W-1:0] r_eps;

    logic           job_valid, q_full, q_empty, en;
    t_job           job, head, div_job;
    logic           div_valid, div_sat;
    logic [T_W-1:0] div_time;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps <= EPS_W'(1);
        end else if (i_cfg_we) begin
            r_eps <= i_cfg_wdata;
        end
    end

    pie_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .o_ready     (o_in_ready),
        .i_item      (i_in_item),
        .o_job_valid (job_valid),
        .i_job_ready (!q_full),
        .o_job       (job)
    );

    pie_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_valid),
        .i_job   (job),
        .o_full  (q_full),
        .i_pop   (en),
        .o_empty (q_empty),
        .o_head  (head)
    );

    pie_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (!q_empty),
        .i_job   (head),
        .o_valid (div_valid),
        .o_job   (div_job),
        .o_time  (div_time),
        .o_sat   (div_sat)
    );

    pie_check #(.FRAC_BITS(FRAC_BITS)) u_check (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .i_job   (div_job),
        .i_time  (div_time),
        .i_sat   (div_sat),
        .i_eps   (r_eps),
        .o_en    (en),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule

`default_nettype wire

FILE: rtl/pie_front.sv
// front end: dot products and move-apart classification
`timescale 1ns / 1ps
`default_nettype none

module pie_front import pie_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_valid,
    output logic       o_ready,
    input  t_in_item   i_item,
    output logic       o_job_valid,
    input  wire        i_job_ready,
    output t_job       o_job
);

    logic               r_valid;
    logic signed [63:0] r_p0, r_p1, r_p2;
    logic        [63:0] r_w0, r_w1, r_w2;
    t_in_item           r_item;
    logic signed [65:0] d;

    assign o_ready = !r_valid || i_job_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
            r_p0   <= i_item.offset_x * i_item.velocity_x;
            r_p1   <= i_item.offset_y * i_item.velocity_y;
            r_p2   <= i_item.offset_z * i_item.velocity_z;
            r_w0   <= 64'(i_item.velocity_x * i_item.velocity_x);
            r_w1   <= 64'(i_item.velocity_y * i_item.velocity_y);
            r_w2   <= 64'(i_item.velocity_z * i_item.velocity_z);
        end
    end

    always_comb begin
        d = 66'(r_p0) + 66'(r_p1) + 66'(r_p2);
        o_job.away = (d > 66'sd0);
        o_job.num  = 64'(-d);
        o_job.den  = r_w0 + r_w1 + r_w2;
        o_job.ox   = r_item.offset_x;
        o_job.oy   = r_item.offset_y;
        o_job.oz   = r_item.offset_z;
        o_job.vx   = r_item.velocity_x;
        o_job.vy   = r_item.velocity_y;
        o_job.vz   = r_item.velocity_z;
        o_job.lim  = r_item.time_limit;
    end

    assign o_job_valid = r_valid;

endmodule

`default_nettype wire

FILE: rtl/pie_queue.sv
// short queue between front and back end
`timescale 1ns / 1ps
`default_nettype none

module pie_queue import pie_pkg::*; (
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_push,
    input  t_job  i_job,
    output logic  o_full,
    input  wire   i_pop,
    output logic  o_empty,
    output t_job  o_head
);

    localparam int unsigned DEPTH = 4;

    t_job       r_mem [DEPTH];
    logic [1:0] r_wr, r_rd;
    logic [2:0] r_cnt;
    logic       push_ok, pop_ok;

    assign o_full  = (r_cnt == 3'(DEPTH));
    assign o_empty = (r_cnt == 3'd0);
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 2'd0;
            r_rd  <= 2'd0;
            r_cnt <= 3'd0;
        end else begin
            if (push_ok) r_wr <= r_wr + 2'd1;
            if (pop_ok)  r_rd <= r_rd + 2'd1;
            r_cnt <= r_cnt + 3'(push_ok) - 3'(pop_ok);
        end
    end

endmodule

`default_nettype wire

FILE: rtl/pie_div.sv
// pipelined restoring divider for the closest-approach time
`timescale 1ns / 1ps
`default_nettype none

module pie_div import pie_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire            i_en,
    input  wire            i_valid,
    input  t_job           i_job,
    output logic           o_valid,
    output t_job           o_job,
    output logic [T_W-1:0] o_time,
    output logic           o_sat
);

    localparam int unsigned NST = T_W + 1;

    logic             r_v    [NST];
    logic [REM_W-1:0] r_rem  [NST];
    logic [T_W-1:0]   r_q    [NST];
    t_job             r_job  [NST];
    logic             r_sat  [NST];
    logic             r_zero [NST];

    logic [REM_W-1:0] rem0;
    logic [REM_W-1:0] lim0;

    // quotient of 2^31 or more saturates
    assign rem0 = REM_W'(i_job.num) << FRAC_BITS;
    assign lim0 = REM_W'(i_job.den) << T_W;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v[0] <= 1'b0;
        end else if (i_en) begin
            r_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= rem0;
            r_q[0]    <= '0;
            r_job[0]  <= i_job;
            r_zero[0] <= (i_job.den == 64'd0);
            r_sat[0]  <= (i_job.den != 64'd0) && (rem0 >= lim0);
        end
    end

    for (genvar j = 1; j < NST; j++) begin : g_stage
        localparam int unsigned K = NST - 1 - j;
        logic [REM_W-1:0] sub;
        logic             take;

        assign sub  = REM_W'(r_job[j-1].den) << K;
        assign take = !r_zero[j-1] && (r_rem[j-1] >= sub);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[j] <= 1'b0;
            end else if (i_en) begin
                r_v[j] <= r_v[j-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j]  <= take ? (r_rem[j-1] - sub) : r_rem[j-1];
                r_q[j]    <= {r_q[j-1][T_W-2:0], take};
                r_job[j]  <= r_job[j-1];
                r_zero[j] <= r_zero[j-1];
                r_sat[j]  <= r_sat[j-1];
            end
        end
    end

    assign o_valid = r_v[NST-1];
    assign o_job   = r_job[NST-1];
    assign o_time  = r_q[NST-1];
    assign o_sat   = r_sat[NST-1];

endmodule

`default_nettype wire

FILE: rtl/pie_check.sv
// limit test, closest point distance test and result register
`timescale 1ns / 1ps
`default_nettype none

module pie_check import pie_pkg::*; #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  t_job             i_job,
    input  wire [T_W-1:0]    i_time,
    input  wire              i_sat,
    input  wire [EPS_W-1:0]  i_eps,
    output logic             o_en,
    output logic             o_valid,
    input  wire              i_ready,
    output t_out_item        o_item
);

    localparam int unsigned EW = EPS_W + FRAC_BITS;
    localparam int unsigned LW = (EW + 1) / 2;
    localparam int unsigned HW = EW - LW;
    localparam int unsigned SW = 2 * EW + 2;

    logic [EW-1:0] e;
    logic [SW-1:0] e2;
    assign e  = EW'(i_eps) << FRAC_BITS;
    assign e2 = SW'(32'(i_eps) * 32'(i_eps)) << (2 * FRAC_BITS);

    assign o_en = !o_valid || i_ready;

    // stage 1: limit and v*t
    logic               r1_v, r1_miss;
    logic [T_W-1:0]     r1_t;
    logic signed [31:0] r1_o [3];
    logic signed [63:0] r1_vt [3];
    logic signed [31:0] t_s;
    logic signed [31:0] vin [3];
    logic signed [31:0] oin [3];

    assign t_s    = signed'({1'b0, i_time});
    assign vin[0] = i_job.vx;
    assign vin[1] = i_job.vy;
    assign vin[2] = i_job.vz;
    assign oin[0] = i_job.ox;
    assign oin[1] = i_job.oy;
    assign oin[2] = i_job.oz;

    // stage 2: closest point magnitude
    logic          r2_v, r2_miss;
    logic [T_W-1:0] r2_t;
    logic [EW-1:0] r2_a [3];
    logic [2:0]    r2_far;

    // stage 3: partial squares
    logic            r3_v, r3_miss;
    logic [T_W-1:0]  r3_t;
    logic [2*HW-1:0] r3_hh [3];
    logic [EW-1:0]   r3_hl [3];
    logic [2*LW-1:0] r3_ll [3];

    logic [SW-1:0] sq [3];
    logic [SW-1:0] dist2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v    <= 1'b0;
            r2_v    <= 1'b0;
            r3_v    <= 1'b0;
            o_valid <= 1'b0;
        end else if (o_en) begin
            r1_v    <= i_valid;
            r2_v    <= r1_v;
            r3_v    <= r2_v;
            o_valid <= r3_v;
        end
    end

    for (genvar k = 0; k < 3; k++) begin : g_axis
        logic signed [65:0] pt;
        logic        [64:0] mag;

        assign pt  = (66'(r1_o[k]) <<< FRAC_BITS) + 66'(r1_vt[k]);
        assign mag = pt[65] ? 65'(-pt) : pt[64:0];

        always_ff @(posedge i_clk) begin
            if (o_en) begin
                r1_o[k]   <= oin[k];
                r1_vt[k]  <= 64'(vin[k] * t_s);
                r2_a[k]   <= mag[EW-1:0];
                r2_far[k] <= (mag > 65'(e));
                r3_hh[k]  <= r2_a[k][EW-1:LW] * r2_a[k][EW-1:LW];
                r3_hl[k]  <= EW'(r2_a[k][EW-1:LW] * r2_a[k][LW-1:0]);
                r3_ll[k]  <= r2_a[k][LW-1:0] * r2_a[k][LW-1:0];
            end
        end

        assign sq[k] = (SW'(r3_hh[k]) << (2 * LW)) + (SW'(r3_hl[k]) << (LW + 1))
                     + SW'(r3_ll[k]);
    end

    assign dist2 = sq[0] + sq[1] + sq[2];

    always_ff @(posedge i_clk) begin
        if (o_en) begin
            r1_t    <= i_time;
            r1_miss <= i_job.away || i_sat || (t_s > i_job.lim);
            r2_t    <= r1_t;
            r2_miss <= r1_miss;
            r3_t    <= r2_t;
            r3_miss <= r2_miss || (|r2_far);
            o_item.hit         <= !r3_miss && (dist2 <= e2);
            o_item.impact_time <= (!r3_miss && (dist2 <= e2)) ? r3_t : '0;
        end
    end

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// self-checking testbench for the particle impact estimator
`timescale 1ns / 1ps

module tb_top;
    import pie_pkg::*;

    localparam int FRAC = 16;
    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES = 200;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_item i_in_item = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_item o_out_item;
    logic i_cfg_we = 1'b0;
    logic [EPS_W-1:0] i_cfg_wdata = '0;

    particle_impact_estimator #(.FRAC_BITS(FRAC)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_item(i_in_item),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_item(o_out_item),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    t_in_item  pending_pairs[$];
    t_out_item expected_impacts[$];
    logic [15:0] epsilon_now = 16'd1;
    int mismatch_count = 0;
    int cycle_count = 0;
    bit quiet_tail = 0;
    bit hold_request = 0;
    bit hold_started = 0;
    int hold_left = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit in_taken = 0;

    function automatic t_out_item predict_impact(t_in_item p, logic [15:0] eps);
        t_out_item r;
        logic signed [63:0] o[3];
        logic signed [63:0] v[3];
        logic signed [129:0] d;
        logic [129:0] w;
        logic [129:0] q;
        logic signed [129:0] pt;
        logic [259:0] sum;
        logic [259:0] e2;
        logic signed [63:0] t;
        r = '0;
        o[0] = p.offset_x; o[1] = p.offset_y; o[2] = p.offset_z;
        v[0] = p.velocity_x; v[1] = p.velocity_y; v[2] = p.velocity_z;
        d = 0; w = 0;
        for (int i = 0; i < 3; i++) begin
            d += o[i] * v[i];
            w += 130'(v[i] * v[i]);
        end
        if (d > 0) return r;
        if (w == 0) t = 0;
        else begin
            q = ((-d) <<< FRAC) / w;
            if (q >= 130'h80000000) return r;
            t = q[63:0];
        end
        if (t > 64'(signed'(p.time_limit))) return r;
        sum = 0;
        for (int i = 0; i < 3; i++) begin
            pt = (130'(o[i]) <<< FRAC) + 130'(v[i]) * 130'(t);
            if (pt < 0) pt = -pt;
            sum += 260'(pt) * 260'(pt);
        end
        e2 = (260'(eps) << FRAC) * (260'(eps) << FRAC);
        if (sum <= e2) begin
            r.hit = 1'b1;
            r.impact_time = t[30:0];
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycle_count);
        mismatch_count++;
    endtask

    // driver: offers the queued pairs
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (!i_in_valid || in_taken) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    i_in_valid <= 1'b0;
                end else if (pending_pairs.size() > 0) begin
                    i_in_item <= pending_pairs.pop_front();
                    i_in_valid <= 1'b1;
                    if (!quiet_tail && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 5);
                end else i_in_valid <= 1'b0;
            end
        end
    end

    // sampled at the rising edge
    always @(posedge i_clk) begin
        in_taken <= i_rst_n && i_in_valid && o_in_ready;
        if (i_rst_n && i_in_valid && o_in_ready)
            expected_impacts.push_back(predict_impact(i_in_item, epsilon_now));
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_impacts.size() == 0) begin
                report_mismatch("unexpected transaction", 32'(o_out_item), 0);
            end else begin
                want = expected_impacts.pop_front();
                if (o_out_item.hit !== want.hit)
                    report_mismatch("hit", 32'(o_out_item.hit), 32'(want.hit));
                if (o_out_item.impact_time !== want.impact_time)
                    report_mismatch("impact_time", 32'(o_out_item.impact_time),
                                    32'(want.impact_time));
            end
        end
    end

    // receiver with random stalls and one long hold-off
    always @(negedge i_clk) begin
        if (hold_request && !hold_started) begin
            hold_started <= 1'b1;
            hold_left <= HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= 1'b0;
        end else if (recv_gap > 0) begin
            recv_gap <= recv_gap - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
            if (!quiet_tail && $urandom_range(0, 9) == 0) recv_gap <= $urandom_range(1, 5);
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > LIMIT_CYCLES) begin
            $display("particle_impact_estimator verification failed");
            $finish;
        end
    end

    function automatic logic [31:0] edge_value();
        case ($urandom_range(0, 6))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0;
            3: return 32'hffff_ffff;
            4: return 32'(signed'($urandom_range(0, 8'hff)) - 128);
            default: return $urandom;
        endcase
    endfunction

    function automatic t_in_item random_pair();
        t_in_item p;
        logic signed [31:0] sc;
        p.offset_x = $urandom; p.offset_y = $urandom; p.offset_z = $urandom;
        p.velocity_x = $urandom; p.velocity_y = $urandom; p.velocity_z = $urandom;
        p.time_limit = $urandom;
        case ($urandom_range(0, 3))
            0: begin
                // scaled-down approaching pair, usually close enough to hit
                sc = signed'(32'($urandom_range(0, 65535))) - 32768;
                p.velocity_x = sc; p.velocity_y = sc >>> 2; p.velocity_z = -sc;
                p.offset_x = -sc * 3 + $urandom_range(0, 3);
                p.offset_y = -(sc >>> 2) * 3;
                p.offset_z = sc * 3;
                p.time_limit = 32'h7fff_ffff;
            end
            1: begin
                p.offset_x = edge_value(); p.velocity_x = edge_value();
                p.offset_y = edge_value(); p.velocity_y = edge_value();
                p.offset_z = edge_value(); p.velocity_z = edge_value();
                p.time_limit = edge_value();
            end
            2: begin
                p.offset_x >>>= 20; p.offset_y >>>= 20; p.offset_z >>>= 20;
                p.velocity_x >>>= 14; p.velocity_y >>>= 14; p.velocity_z >>>= 14;
                if ($urandom_range(0, 1)) p.time_limit >>>= 8;
            end
            default: ;
        endcase
        return p;
    endfunction

    task automatic wait_idle();
        while (pending_pairs.size() > 0 || i_in_valid || expected_impacts.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_epsilon(logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        epsilon_now = value;
    endtask

    initial begin
        t_in_item p;
        logic [15:0] eps_list[4];
        eps_list = '{16'd0, 16'hffff, 16'd300, 16'd1};
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: extremes, zero velocity, moving apart, negative limit
        p = '0; pending_pairs.push_back(p);
        p.time_limit = -1; pending_pairs.push_back(p);
        p = '0; p.offset_x = 32'h10000; p.velocity_x = 32'h10000; pending_pairs.push_back(p);
        p = '0; p.offset_x = 32'h10000; p.velocity_x = -32'sh10000;
        p.time_limit = 32'h7fff_ffff; pending_pairs.push_back(p);
        p.time_limit = 32'h8000; pending_pairs.push_back(p);
        p = '0; p.offset_x = 32'h7fff_ffff; p.velocity_x = 32'h1;
        p.offset_y = 32'h1; p.velocity_y = 32'h0; p.time_limit = 32'h7fff_ffff;
        p.velocity_x = -32'sd1; pending_pairs.push_back(p);
        p = '0; p.offset_x = 32'h8000_0000; p.velocity_x = 32'h7fff_ffff;
        p.offset_y = 32'h8000_0000; p.velocity_y = 32'h7fff_ffff;
        p.offset_z = 32'h8000_0000; p.velocity_z = 32'h7fff_ffff;
        p.time_limit = 32'h7fff_ffff; pending_pairs.push_back(p);
        p = '1; pending_pairs.push_back(p);
        p = '0; p.offset_x = 32'h1; p.time_limit = 32'h8000_0000; pending_pairs.push_back(p);
        p = '0; p.offset_z = 32'h2_0000; p.velocity_z = 32'h8000_0000;
        p.offset_y = 32'h1; p.time_limit = 32'h7fff_ffff; pending_pairs.push_back(p);
        for (int i = 0; i < 10; i++) pending_pairs.push_back(random_pair());
        wait_idle();

        // random phases over several epsilon settings
        for (int ph = 0; ph < 4; ph++) begin
            write_epsilon(eps_list[ph]);
            if (ph == 3) quiet_tail = 1;
            for (int i = 0; i < 320; i++) pending_pairs.push_back(random_pair());
            if (ph == 1) begin
                // long receiver hold-off so the input stalls
                @(negedge i_clk);
                hold_request <= 1'b1;
            end
            wait_idle();
        end

        if (mismatch_count == 0 && expected_impacts.size() == 0)
            $display("particle_impact_estimator verification clean");
        else
            $display("particle_impact_estimator verification failed");
        $finish;
    end
endmodule
